### design/hps_pkg.sv
// Shared types, codes and constants for the hex-prism crystal growth lattice.
package hps_pkg;

   typedef enum logic [1:0] {
      REQ_FILL = 2'd0,
      REQ_STEP = 2'd1,
      REQ_READ = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_ALPHA = 2'd0,
      CSR_BETA  = 2'd1,
      CSR_GAMMA = 2'd2,
      CSR_VBIAS = 2'd3
   } csr_index_type;

   localparam int MASS_W  = 24;
   localparam int ALPHA_W = 22;
   localparam int BETA_W  = 20;
   localparam int GAMMA_W = 14;
   localparam int VBIAS_W = 21;

   localparam logic [MASS_W-1:0]  MASS_ONE  = 24'h100000;
   localparam logic [MASS_W-1:0]  MASS_MAX  = 24'hFFFFFF;
   localparam logic [ALPHA_W-1:0] ALPHA_RST = 22'd1048576;
   localparam logic [BETA_W-1:0]  BETA_RST  = 20'd419430;
   localparam logic [GAMMA_W-1:0] GAMMA_RST = 14'd1049;
   localparam logic [VBIAS_W-1:0] VBIAS_RST = 21'd104858;

   localparam int TAP_W = 4;
   localparam logic [TAP_W-1:0] TAP_SELF = 4'd0;
   localparam logic [TAP_W-1:0] TAP_QP   = 4'd1;
   localparam logic [TAP_W-1:0] TAP_QM   = 4'd2;
   localparam logic [TAP_W-1:0] TAP_RP   = 4'd3;
   localparam logic [TAP_W-1:0] TAP_RM   = 4'd4;
   localparam logic [TAP_W-1:0] TAP_QPRM = 4'd5;
   localparam logic [TAP_W-1:0] TAP_QMRP = 4'd6;
   localparam logic [TAP_W-1:0] TAP_ZP   = 4'd7;
   localparam logic [TAP_W-1:0] TAP_ZM   = 4'd8;
   localparam logic [TAP_W-1:0] TAP_LAST = 4'd9;

   localparam int SUM_W  = 27;
   localparam int MAG_W  = 27;
   localparam int FAC_W  = 22;
   localparam int PROD_W = MAG_W + FAC_W;
   localparam int RND_W  = PROD_W + 2;
   localparam int TOT_W  = 30;

   localparam logic [RND_W-1:0] HALF_LONG  = RND_W'(1) << 23;
   localparam logic [RND_W-1:0] HALF_SHORT = RND_W'(1) << 19;

   typedef struct packed {
      logic q_lo;
      logic q_hi;
      logic r_lo;
      logic r_hi;
      logic z_lo;
      logic z_hi;
   } edge_type;

   typedef struct packed {
      logic start;
      logic short_shift;
   } mul_ctl_type;

endpackage

### design/hps_mul_round.sv
// Shared two-stage multiply with round-half-away scaling by 2^24 or 2^20.
module hps_mul_round import hps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mul_ctl_type       ctl,
   input  logic [MAG_W-1:0]  mag,
   input  logic [FAC_W-1:0]  factor,
   output logic              done,
   output logic [MAG_W-1:0]  result
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              short_ff, short_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MAG_W-1:0]  result_ff, result_in;
   logic [RND_W-1:0]  rnd_sum;

   always_comb begin
      prod_in  = PROD_W'(mag) * PROD_W'(factor);
      short_in = ctl.short_shift;
      busy_in  = ctl.start;
      rnd_sum  = RND_W'(prod_ff) + (short_ff ? HALF_SHORT : HALF_LONG);
      done_in  = busy_ff;
      if (short_ff) begin
         result_in = rnd_sum[20 +: MAG_W];
      end else begin
         result_in = rnd_sum[24 +: MAG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff   <= prod_in;
      short_ff  <= short_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### design/hps_nbr.sv
// Stencil address generator: neighbour address and in-lattice flag per tap.
module hps_nbr import hps_pkg::*; #(
   parameter int GRID_SIDE   = 31,
   parameter int LAYER_COUNT = 16
) (
   input  logic [$clog2(GRID_SIDE*GRID_SIDE*LAYER_COUNT)-1:0] idx,
   input  edge_type                                           edges,
   input  logic [TAP_W-1:0]                                   tap,
   output logic                                               ok,
   output logic [$clog2(GRID_SIDE*GRID_SIDE*LAYER_COUNT)-1:0] addr
);

   localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE * LAYER_COUNT);
   localparam logic [ADDR_W-1:0] ROW   = ADDR_W'(GRID_SIDE);
   localparam logic [ADDR_W-1:0] PLANE = ADDR_W'(GRID_SIDE * GRID_SIDE);
   localparam logic [ADDR_W-1:0] ONE   = ADDR_W'(1);

   logic [ADDR_W-1:0] cand;
   logic              cand_ok;

   always_comb begin
      case (tap)
         TAP_QP: begin
            cand_ok = !edges.q_hi;
            cand    = idx + ONE;
         end
         TAP_QM: begin
            cand_ok = !edges.q_lo;
            cand    = idx - ONE;
         end
         TAP_RP: begin
            cand_ok = !edges.r_hi;
            cand    = idx + ROW;
         end
         TAP_RM: begin
            cand_ok = !edges.r_lo;
            cand    = idx - ROW;
         end
         TAP_QPRM: begin
            cand_ok = !edges.q_hi && !edges.r_lo;
            cand    = idx + ONE - ROW;
         end
         TAP_QMRP: begin
            cand_ok = !edges.q_lo && !edges.r_hi;
            cand    = idx - ONE + ROW;
         end
         TAP_ZP: begin
            cand_ok = !edges.z_hi;
            cand    = idx + PLANE;
         end
         TAP_ZM: begin
            cand_ok = !edges.z_lo;
            cand    = idx - PLANE;
         end
         default: begin
            cand_ok = 1'b1;
            cand    = idx;
         end
      endcase
      ok   = cand_ok;
      addr = cand_ok ? cand : idx;
   end

endmodule

### design/hex_prism_snowflake_ca_step.sv
// Top level: hex-prism crystal growth lattice with fill, step and read requests.
// One request beat gives one response beat. A read in range passes through the RD0,
// RD1 and DONE states before its response beat, an out-of-range read or an unused
// request type goes straight to DONE. A fill (request type 0, and once after reset,
// during which no request is taken) writes one cell a cycle until it has written all
// GRID_SIDE*GRID_SIDE*LAYER_COUNT cells, 15376 with the default sizes. A step sweeps
// the lattice twice with one stencil read a cycle from single-port-read mass and
// diffusion memories, pausing for the multiplier: the first pass reads the stencil of
// each hexagon cell, the second that of each interior hexagon cell and then runs the
// shared multiplier once or twice, and the remaining cells are passed over. Configuration
// beats are taken only while idle with no request beat offered.
module hex_prism_snowflake_ca_step import hps_pkg::*; #(
   parameter int HEX_RADIUS  = 15,
   parameter int LAYER_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_q[4:0], cell_r[9:5], cell_z[13:10], zero
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cell_mass[23:0], cell_frozen[24], step_count[56:25]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_data
);

   localparam int GRID_SIDE = 2 * HEX_RADIUS + 1;
   localparam int PLANE     = GRID_SIDE * GRID_SIDE;
   localparam int CELLS     = PLANE * LAYER_COUNT;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int CW        = $clog2(GRID_SIDE);
   localparam int ZW        = $clog2(LAYER_COUNT);
   localparam int CENTRE    = ((LAYER_COUNT / 2) * GRID_SIDE + HEX_RADIUS) * GRID_SIDE
                              + HEX_RADIUS;
   localparam logic [ADDR_W-1:0] CENTRE_ADDR = ADDR_W'(CENTRE);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
   localparam logic [CW-1:0]     LAST_QR     = CW'(GRID_SIDE - 1);
   localparam logic [ZW-1:0]     LAST_Z      = ZW'(LAYER_COUNT - 1);
   localparam logic [CW:0]       HEX_LO      = (CW+1)'(HEX_RADIUS);
   localparam logic [CW:0]       HEX_HI      = (CW+1)'(3 * HEX_RADIUS);

   typedef enum logic [3:0] {
      ST_FILL, ST_IDLE, ST_RD0, ST_RD1, ST_P1, ST_P2, ST_DIFF, ST_MUL, ST_MWAIT,
      ST_WR, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [CW-1:0]        q_ff, q_in, r_ff, r_in;
   logic [ZW-1:0]        z_ff, z_in;
   logic [TAP_W-1:0]     tap_ff, tap_in;
   logic                 ok_ff, ok_in;
   logic [MASS_W-1:0]    self_mass_ff, self_mass_in;
   logic                 self_frz_ff, self_frz_in;
   logic                 horiz_ff, horiz_in, vert_ff, vert_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [MASS_W-1:0]    u_ff, u_in, held_ff, held_in;
   logic                 fast_ff, fast_in;
   logic                 xneg_ff, xneg_in;
   logic [MAG_W-1:0]     xmag_ff, xmag_in, inf_ff, inf_in;
   logic                 second_ff, second_in;
   logic [31:0]          step_ff, step_in;
   logic [MASS_W-1:0]    res_ff, res_in;
   logic                 fill_rsp_ff, fill_rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_data_ff, rsp_data_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [BETA_W-1:0]    beta_ff, beta_in;
   logic [GAMMA_W-1:0]   gamma_ff, gamma_in;
   logic [VBIAS_W-1:0]   vbias_ff, vbias_in;

   logic [MASS_W-1:0]    mass_mem [CELLS];
   logic [MASS_W-1:0]    diff_mem [CELLS];
   logic [MASS_W-1:0]    held_mem [CELLS];
   logic                 fast_mem [CELLS];
   logic [MASS_W-1:0]    mass_rd_ff, diff_rd_ff, held_rd_ff;
   logic                 fast_rd_ff;

   logic                 mass_we, part_we;
   logic [ADDR_W-1:0]    mass_raddr;
   logic [MASS_W-1:0]    mass_wdata, diff_wdata, held_wdata;
   logic                 fast_wdata;

   edge_type             edges;
   logic                 nbr_ok;
   logic [ADDR_W-1:0]    nbr_addr;
   mul_ctl_type          mul_ctl;
   logic [MAG_W-1:0]     mul_mag, mul_res;
   logic [FAC_W-1:0]     mul_fac;
   logic                 mul_done;

   logic                 req_fire;
   logic                 csr_fire;
   req_kind_type         kind;
   logic [4:0]           req_q, req_r;
   logic [3:0]           req_z;
   logic [CW:0]          qr_sum;
   logic                 in_hex, interior, last_cell, frz_data;
   logic                 horiz_now, vert_now, receptive;
   logic [MASS_W:0]      gain;
   logic [MASS_W-1:0]    dval;
   logic [SUM_W:0]       xval;
   logic [TOT_W-1:0]     sinf, total;
   logic                 load_rsp;

   hps_nbr #(
      .GRID_SIDE   (GRID_SIDE),
      .LAYER_COUNT (LAYER_COUNT)
   ) u_nbr (
      .idx   (idx_ff),
      .edges (edges),
      .tap   (tap_ff),
      .ok    (nbr_ok),
      .addr  (nbr_addr)
   );

   hps_mul_round u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .mag    (mul_mag),
      .factor (mul_fac),
      .done   (mul_done),
      .result (mul_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE) && !req_tvalid;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign kind       = req_kind_type'(req_tuser);
   assign req_q      = req_tdata[4:0];
   assign req_r      = req_tdata[9:5];
   assign req_z      = req_tdata[13:10];

   assign edges.q_lo = (q_ff == '0);
   assign edges.q_hi = (q_ff == LAST_QR);
   assign edges.r_lo = (r_ff == '0);
   assign edges.r_hi = (r_ff == LAST_QR);
   assign edges.z_lo = (z_ff == '0);
   assign edges.z_hi = (z_ff == LAST_Z);

   assign qr_sum    = (CW+1)'(q_ff) + (CW+1)'(r_ff);
   assign in_hex    = (qr_sum >= HEX_LO) && (qr_sum <= HEX_HI);
   assign interior  = in_hex && !edges.q_lo && !edges.q_hi && !edges.r_lo && !edges.r_hi;
   assign last_cell = edges.q_hi && edges.r_hi && edges.z_hi;

   assign frz_data  = ok_ff && (mass_rd_ff >= MASS_ONE);
   assign horiz_now = horiz_ff || (frz_data && (tap_ff >= TAP_QM) && (tap_ff <= TAP_ZP));
   assign vert_now  = vert_ff || (frz_data && ((tap_ff == TAP_ZM) || (tap_ff == TAP_LAST)));
   assign receptive = self_frz_ff || horiz_now || vert_now;
   assign gain      = (MASS_W+1)'(self_mass_ff) + (MASS_W+1)'(gamma_ff);
   assign dval      = ok_ff ? diff_rd_ff : MASS_W'(beta_ff);
   assign xval      = (SUM_W+1)'(sum_ff) - (SUM_W+1)'({u_ff, 3'b000});
   assign sinf      = xneg_ff ? (TOT_W'(0) - TOT_W'(inf_ff)) : TOT_W'(inf_ff);
   assign total     = TOT_W'(u_ff) + TOT_W'(held_ff) + sinf;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign mul_mag   = second_ff ? inf_ff : xmag_ff;
   assign mul_fac   = second_ff ? FAC_W'(vbias_ff) : alpha_ff;
   assign mul_ctl.start       = (state_ff == ST_MUL);
   assign mul_ctl.short_shift = second_ff;

   assign mass_raddr = (state_ff == ST_RD0) ? addr_ff : nbr_addr;

   always_comb begin
      mass_we    = 1'b0;
      part_we    = 1'b0;
      mass_wdata = MASS_W'(beta_ff);
      diff_wdata = MASS_W'(beta_ff);
      held_wdata = '0;
      fast_wdata = 1'b1;
      case (state_ff)
         ST_FILL: begin
            mass_we    = 1'b1;
            mass_wdata = (idx_ff == CENTRE_ADDR) ? MASS_ONE : MASS_W'(beta_ff);
         end
         ST_P1: begin
            if (tap_ff == TAP_SELF && !in_hex) begin
               mass_we = 1'b1;
               part_we = 1'b1;
            end else if (tap_ff == TAP_LAST) begin
               part_we    = 1'b1;
               fast_wdata = self_frz_ff || horiz_now;
               if (receptive) begin
                  diff_wdata = '0;
                  held_wdata = gain[MASS_W] ? MASS_MAX : gain[MASS_W-1:0];
               end else begin
                  diff_wdata = self_mass_ff;
                  held_wdata = '0;
               end
            end
         end
         ST_WR: begin
            mass_we = 1'b1;
            if (total[TOT_W-1]) begin
               mass_wdata = '0;
            end else if (total > TOT_W'(MASS_MAX)) begin
               mass_wdata = MASS_MAX;
            end else begin
               mass_wdata = total[MASS_W-1:0];
            end
         end
         default: begin
            mass_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mass_we) begin
         mass_mem[idx_ff] <= mass_wdata;
      end
      if (part_we) begin
         diff_mem[idx_ff] <= diff_wdata;
         held_mem[idx_ff] <= held_wdata;
         fast_mem[idx_ff] <= fast_wdata;
      end
      mass_rd_ff <= mass_mem[mass_raddr];
      diff_rd_ff <= diff_mem[nbr_addr];
      held_rd_ff <= held_mem[nbr_addr];
      fast_rd_ff <= fast_mem[nbr_addr];
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      z_in         = z_ff;
      tap_in       = tap_ff;
      ok_in        = nbr_ok;
      self_mass_in = self_mass_ff;
      self_frz_in  = self_frz_ff;
      horiz_in     = horiz_ff;
      vert_in      = vert_ff;
      sum_in       = sum_ff;
      u_in         = u_ff;
      held_in      = held_ff;
      fast_in      = fast_ff;
      xneg_in      = xneg_ff;
      xmag_in      = xmag_ff;
      inf_in       = inf_ff;
      second_in    = second_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      fill_rsp_in  = fill_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      gamma_in     = gamma_ff;
      vbias_in     = vbias_ff;

      if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALPHA: alpha_in = csr_data[ALPHA_W-1:0];
            CSR_BETA:  beta_in  = csr_data[BETA_W-1:0];
            CSR_GAMMA: gamma_in = csr_data[GAMMA_W-1:0];
            CSR_VBIAS: vbias_in = csr_data[VBIAS_W-1:0];
            default:   alpha_in = alpha_ff;
         endcase
      end

      unique case (state_ff)
         ST_FILL: begin
            idx_in = idx_ff + ADDR_W'(1);
            if (idx_ff == LAST_ADDR) begin
               idx_in      = '0;
               res_in      = '0;
               fill_rsp_in = 1'b0;
               state_in    = fill_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               idx_in    = '0;
               q_in      = '0;
               r_in      = '0;
               z_in      = '0;
               tap_in    = TAP_SELF;
               res_in    = '0;
               horiz_in  = 1'b0;
               vert_in   = 1'b0;
               unique case (kind)
                  REQ_FILL: begin
                     step_in     = '0;
                     fill_rsp_in = 1'b1;
                     state_in    = ST_FILL;
                  end
                  REQ_STEP: begin
                     state_in = ST_P1;
                  end
                  REQ_READ: begin
                     addr_in = ADDR_W'(32'(req_z) * 32'(PLANE) + 32'(req_r) * 32'(GRID_SIDE)
                                       + 32'(req_q));
                     if (32'(req_q) < 32'(GRID_SIDE) && 32'(req_r) < 32'(GRID_SIDE) &&
                         32'(req_z) < 32'(LAYER_COUNT)) begin
                        state_in = ST_RD0;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            res_in   = mass_rd_ff;
            state_in = ST_DONE;
         end
         ST_P1: begin
            tap_in = tap_ff + TAP_W'(1);
            if (tap_ff == TAP_QP) begin
               self_mass_in = mass_rd_ff;
               self_frz_in  = frz_data;
            end
            horiz_in = horiz_now;
            vert_in  = vert_now;
            if ((tap_ff == TAP_SELF && !in_hex) || tap_ff == TAP_LAST) begin
               tap_in   = TAP_SELF;
               horiz_in = 1'b0;
               vert_in  = 1'b0;
               idx_in   = idx_ff + ADDR_W'(1);
               q_in     = q_ff + CW'(1);
               if (edges.q_hi) begin
                  q_in = '0;
                  r_in = r_ff + CW'(1);
                  if (edges.r_hi) begin
                     r_in = '0;
                     z_in = z_ff + ZW'(1);
                  end
               end
               if (last_cell) begin
                  idx_in   = '0;
                  z_in     = '0;
                  state_in = ST_P2;
               end
            end
         end
         ST_P2: begin
            tap_in = tap_ff + TAP_W'(1);
            if (tap_ff == TAP_SELF) begin
               sum_in = '0;
            end else if (tap_ff == TAP_QP) begin
               u_in    = diff_rd_ff;
               held_in = held_rd_ff;
               fast_in = fast_rd_ff;
            end else begin
               sum_in = sum_ff + SUM_W'(dval);
            end
            if (tap_ff == TAP_LAST) begin
               tap_in   = TAP_SELF;
               state_in = ST_DIFF;
            end else if (tap_ff == TAP_SELF && !interior) begin
               tap_in = TAP_SELF;
               idx_in = idx_ff + ADDR_W'(1);
               q_in   = q_ff + CW'(1);
               if (edges.q_hi) begin
                  q_in = '0;
                  r_in = r_ff + CW'(1);
                  if (edges.r_hi) begin
                     r_in = '0;
                     z_in = z_ff + ZW'(1);
                  end
               end
               if (last_cell) begin
                  step_in  = step_ff + 32'd1;
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIFF: begin
            xneg_in   = xval[SUM_W];
            xmag_in   = xval[SUM_W] ? MAG_W'((SUM_W+1)'(0) - xval) : MAG_W'(xval);
            second_in = 1'b0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               inf_in = mul_res;
               if (!second_ff && !fast_ff) begin
                  second_in = 1'b1;
                  state_in  = ST_MUL;
               end else begin
                  state_in = ST_WR;
               end
            end
         end
         ST_WR: begin
            tap_in   = TAP_SELF;
            state_in = ST_P2;
            idx_in   = idx_ff + ADDR_W'(1);
            q_in     = q_ff + CW'(1);
            if (edges.q_hi) begin
               q_in = '0;
               r_in = r_ff + CW'(1);
               if (edges.r_hi) begin
                  r_in = '0;
                  z_in = z_ff + ZW'(1);
               end
            end
            if (last_cell) begin
               step_in  = step_ff + 32'd1;
               res_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, step_ff, (res_ff >= MASS_ONE), res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         idx_ff       <= '0;
         q_ff         <= '0;
         r_ff         <= '0;
         z_ff         <= '0;
         tap_ff       <= TAP_SELF;
         horiz_ff     <= 1'b0;
         vert_ff      <= 1'b0;
         second_ff    <= 1'b0;
         step_ff      <= '0;
         fill_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= ALPHA_RST;
         beta_ff      <= BETA_RST;
         gamma_ff     <= GAMMA_RST;
         vbias_ff     <= VBIAS_RST;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         z_ff         <= z_in;
         tap_ff       <= tap_in;
         horiz_ff     <= horiz_in;
         vert_ff      <= vert_in;
         second_ff    <= second_in;
         step_ff      <= step_in;
         fill_rsp_ff  <= fill_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         gamma_ff     <= gamma_in;
         vbias_ff     <= vbias_in;
      end
      addr_ff      <= addr_in;
      ok_ff        <= ok_in;
      self_mass_ff <= self_mass_in;
      self_frz_ff  <= self_frz_in;
      sum_ff       <= sum_in;
      u_ff         <= u_in;
      held_ff      <= held_in;
      fast_ff      <= fast_in;
      xneg_ff      <= xneg_in;
      xmag_ff      <= xmag_in;
      inf_ff       <= inf_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response beat raised outside the done state");

   a_frozen_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24] == (rsp_tdata[23:20] != 4'd0)))
      else $error("frozen flag disagrees with returned mass");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= TAP_LAST)
      else $error("stencil tap counter out of range");

endmodule
